// ----- hw/rtl/i2cmbw_pkg.sv -----
// ---------------------------------------------------------------------------
// i2cmbw_pkg
// Shared types and constants for the I2C master byte writer.
// ---------------------------------------------------------------------------
package i2cmbw_pkg;

  localparam int DelayWidth = 16;
  localparam logic [DelayWidth-1:0] DelayReset = 16'd100;
  localparam int ByteWidth = 8;
  localparam int BitCntWidth = $clog2(ByteWidth);
  localparam logic [BitCntWidth-1:0] LastBit = BitCntWidth'(ByteWidth - 1);

  // bus phase sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_HOLD,
    ST_START_SDA,
    ST_START_SCL,
    ST_BIT_SET,
    ST_BIT_HIGH,
    ST_BIT_LOW,
    ST_ACK_REL,
    ST_ACK_HIGH,
    ST_ACK_LOW,
    ST_ACK_DRIVE,
    ST_STOP_HIGH,
    ST_STOP_REL
  } state_t;

  // line operation applied on a phase step
  typedef enum logic [2:0] {
    LN_HOLD,
    LN_SDA_LOW,
    LN_SCL_LOW,
    LN_SDA_MSB,
    LN_SCL_HIGH,
    LN_SCL_LOW_SHIFT,
    LN_SDA_REL,
    LN_SCL_HIGH_SAMPLE
  } line_op_t;

  typedef struct packed {
    logic     load;   // take a new input word
    logic     step;   // run one bus phase
    line_op_t op;
    logic     last;   // final phase of the byte
  } cmd_t;

  typedef struct packed {
    logic can_step;   // hold time elapsed and output register free
    logic bits_done;  // current data bit is the eighth
    logic stop_req;
  } sts_t;

endpackage

// ----- hw/rtl/i2cmbw_if.sv -----
// ---------------------------------------------------------------------------
// i2cmbw channel interfaces
// Valid/ready channels for input bytes, bus phase results and configuration.
// ---------------------------------------------------------------------------
interface i2cmbw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       send_start;
  logic       send_stop;
  logic       ack_level;

  modport source (output valid, output byte_value, output send_start,
                  output send_stop, output ack_level, input ready);
  modport sink (input valid, input byte_value, input send_start,
                input send_stop, input ack_level, output ready);
endinterface

interface i2cmbw_out_if;
  logic valid;
  logic ready;
  logic scl_level;
  logic sda_level;
  logic acked;
  logic last_phase;

  modport source (output valid, output scl_level, output sda_level,
                  output acked, output last_phase, input ready);
  modport sink (input valid, input scl_level, input sda_level,
                input acked, input last_phase, output ready);
endinterface

interface i2cmbw_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/i2cmbw_ctrl.sv -----
// ---------------------------------------------------------------------------
// i2cmbw_ctrl
// Bus phase sequencer: walks START, data bits, ACK and STOP phases.
// ---------------------------------------------------------------------------
module i2cmbw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_start,
  output logic               in_ready,
  input  i2cmbw_pkg::sts_t   sts,
  output i2cmbw_pkg::cmd_t   cmd
);

  i2cmbw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2cmbw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.op     = i2cmbw_pkg::LN_HOLD;
    cmd.last   = 1'b0;
    in_ready   = (state == i2cmbw_pkg::ST_IDLE);
    case (state)
      i2cmbw_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = in_start ? i2cmbw_pkg::ST_START_HOLD : i2cmbw_pkg::ST_BIT_SET;
        end
      end
      i2cmbw_pkg::ST_START_HOLD: begin
        cmd.op = i2cmbw_pkg::LN_HOLD;
        if (sts.can_step) state_next = i2cmbw_pkg::ST_START_SDA;
      end
      i2cmbw_pkg::ST_START_SDA: begin
        cmd.op = i2cmbw_pkg::LN_SDA_LOW;
        if (sts.can_step) state_next = i2cmbw_pkg::ST_START_SCL;
      end
      i2cmbw_pkg::ST_START_SCL: begin
        cmd.op = i2cmbw_pkg::LN_SCL_LOW;
        if (sts.can_step) state_next = i2cmbw_pkg::ST_BIT_SET;
      end
      i2cmbw_pkg::ST_BIT_SET: begin
        cmd.op = i2cmbw_pkg::LN_SDA_MSB;
        if (sts.can_step) state_next = i2cmbw_pkg::ST_BIT_HIGH;
      end
      i2cmbw_pkg::ST_BIT_HIGH: begin
        cmd.op = i2cmbw_pkg::LN_SCL_HIGH;
        if (sts.can_step) state_next = i2cmbw_pkg::ST_BIT_LOW;
      end
      i2cmbw_pkg::ST_BIT_LOW: begin
        cmd.op = i2cmbw_pkg::LN_SCL_LOW_SHIFT;
        if (sts.can_step) begin
          state_next = sts.bits_done ? i2cmbw_pkg::ST_ACK_REL : i2cmbw_pkg::ST_BIT_SET;
        end
      end
      i2cmbw_pkg::ST_ACK_REL: begin
        cmd.op = i2cmbw_pkg::LN_SDA_REL;
        if (sts.can_step) state_next = i2cmbw_pkg::ST_ACK_HIGH;
      end
      i2cmbw_pkg::ST_ACK_HIGH: begin
        cmd.op = i2cmbw_pkg::LN_SCL_HIGH_SAMPLE;
        if (sts.can_step) state_next = i2cmbw_pkg::ST_ACK_LOW;
      end
      i2cmbw_pkg::ST_ACK_LOW: begin
        cmd.op = i2cmbw_pkg::LN_SCL_LOW;
        if (sts.can_step) state_next = i2cmbw_pkg::ST_ACK_DRIVE;
      end
      i2cmbw_pkg::ST_ACK_DRIVE: begin
        cmd.op   = i2cmbw_pkg::LN_SDA_LOW;
        cmd.last = !sts.stop_req;
        if (sts.can_step) begin
          state_next = sts.stop_req ? i2cmbw_pkg::ST_STOP_HIGH : i2cmbw_pkg::ST_IDLE;
        end
      end
      i2cmbw_pkg::ST_STOP_HIGH: begin
        cmd.op = i2cmbw_pkg::LN_SCL_HIGH;
        if (sts.can_step) state_next = i2cmbw_pkg::ST_STOP_REL;
      end
      i2cmbw_pkg::ST_STOP_REL: begin
        cmd.op   = i2cmbw_pkg::LN_SDA_REL;
        cmd.last = 1'b1;
        if (sts.can_step) state_next = i2cmbw_pkg::ST_IDLE;
      end
      default: begin
        state_next = i2cmbw_pkg::ST_IDLE;
      end
    endcase
    cmd.step = sts.can_step && (state != i2cmbw_pkg::ST_IDLE);
  end

  // a taken word always starts a phase sequence
  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state != i2cmbw_pkg::ST_IDLE)
    else $error("sequencer stayed idle after taking a word");

  // the final phase returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.step && cmd.last |=> state == i2cmbw_pkg::ST_IDLE)
    else $error("sequencer not idle after final phase");

  // idle is left only by taking a word
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    state == i2cmbw_pkg::ST_IDLE && !in_valid |=> state == i2cmbw_pkg::ST_IDLE)
    else $error("sequencer left idle without a word");

endmodule

// ----- hw/rtl/i2cmbw_dp.sv -----
// ---------------------------------------------------------------------------
// i2cmbw_dp
// Line registers, shift register, hold timer and output register.
// ---------------------------------------------------------------------------
module i2cmbw_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  i2cmbw_pkg::cmd_t     cmd,
  output i2cmbw_pkg::sts_t     sts,
  i2cmbw_in_if.sink            in_word,
  i2cmbw_out_if.source         out_word,
  i2cmbw_cfg_if.sink           cfg
);

  logic [i2cmbw_pkg::ByteWidth-1:0]   shift_reg;
  logic [i2cmbw_pkg::BitCntWidth-1:0] bit_cnt;
  logic                               stop_req;
  logic                               ack_level;
  logic                               ack_flag;
  logic                               scl_out;
  logic                               sda_out;
  logic [i2cmbw_pkg::DelayWidth-1:0]  delay_count;
  logic [i2cmbw_pkg::DelayWidth-1:0]  phase_delay;
  logic                               out_valid;
  logic                               out_scl;
  logic                               out_sda;
  logic                               out_acked;
  logic                               out_last;
  logic                               scl_next;
  logic                               sda_next;
  logic                               ack_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_delay <= i2cmbw_pkg::DelayReset;
    end else if (cfg.valid) begin
      phase_delay <= cfg.data;
    end
  end

  // line levels after this phase's change
  always_comb begin
    scl_next = scl_out;
    sda_next = sda_out;
    ack_next = ack_flag;
    case (cmd.op)
      i2cmbw_pkg::LN_HOLD:            ;
      i2cmbw_pkg::LN_SDA_LOW:         sda_next = 1'b0;
      i2cmbw_pkg::LN_SCL_LOW:         scl_next = 1'b0;
      i2cmbw_pkg::LN_SDA_MSB:         sda_next = shift_reg[i2cmbw_pkg::ByteWidth-1];
      i2cmbw_pkg::LN_SCL_HIGH:        scl_next = 1'b1;
      i2cmbw_pkg::LN_SCL_LOW_SHIFT:   scl_next = 1'b0;
      i2cmbw_pkg::LN_SDA_REL:         sda_next = 1'b1;
      i2cmbw_pkg::LN_SCL_HIGH_SAMPLE: begin
        scl_next = 1'b1;
        ack_next = !ack_level;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_out     <= 1'b1;
      sda_out     <= 1'b1;
      ack_flag    <= 1'b0;
      bit_cnt     <= '0;
      delay_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        bit_cnt <= '0;
      end
      if (cmd.step) begin
        scl_out     <= scl_next;
        sda_out     <= sda_next;
        ack_flag    <= ack_next;
        delay_count <= phase_delay;
        out_valid   <= 1'b1;
        if (cmd.op == i2cmbw_pkg::LN_SCL_LOW_SHIFT) begin
          bit_cnt <= bit_cnt + 1'b1;
        end
      end else begin
        if (delay_count != '0) delay_count <= delay_count - 1'b1;
        if (out_word.ready) out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shift_reg <= in_word.byte_value;
      stop_req  <= in_word.send_stop;
      ack_level <= in_word.ack_level;
    end else if (cmd.step && cmd.op == i2cmbw_pkg::LN_SCL_LOW_SHIFT) begin
      shift_reg <= {shift_reg[i2cmbw_pkg::ByteWidth-2:0], 1'b0};
    end
    if (cmd.step) begin
      out_scl   <= scl_next;
      out_sda   <= sda_next;
      out_acked <= cmd.last && ack_next;
      out_last  <= cmd.last;
    end
  end

  assign sts.can_step  = (delay_count == '0) && (!out_valid || out_word.ready);
  assign sts.bits_done = (bit_cnt == i2cmbw_pkg::LastBit);
  assign sts.stop_req  = stop_req;

  assign out_word.valid      = out_valid;
  assign out_word.scl_level  = out_scl;
  assign out_word.sda_level  = out_sda;
  assign out_word.acked      = out_acked;
  assign out_word.last_phase = out_last;

  // a phase never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !out_valid || out_word.ready)
    else $error("phase result overwritten before taken");

  // each phase restarts the hold timer
  a_hold_reload: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> delay_count == $past(phase_delay) && out_valid)
    else $error("hold timer not reloaded on phase");

  // the eighth bit wraps the bit counter
  a_bit_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.step && cmd.op == i2cmbw_pkg::LN_SCL_LOW_SHIFT && sts.bits_done
    |=> bit_cnt == '0)
    else $error("bit counter did not wrap after eighth bit");

endmodule

// ----- hw/rtl/i2c_master_byte_writer_unit.sv -----
// ---------------------------------------------------------------------------
// i2c_master_byte_writer_unit
// Write-only I2C master that turns bytes into a stream of bus phase words.
// ---------------------------------------------------------------------------
// Each input word is one byte plus START/STOP requests and the ACK level the
// target will show. The block emits one output word per bus phase carrying
// the SCL and SDA levels: 3 phases for an optional START, 3 per data bit
// (MSB first), 4 for the acknowledge, 2 for an optional STOP, so 28 to 33
// words per byte. Every phase is held by a 16-bit down counter loaded from
// phase_delay; the next phase waits until the counter is zero and the sink
// has taken the previous word, so the hold counter and the sink set the
// pace. Between bytes the sequencer passes through its idle state to take
// the next word. The final word of a byte has last_phase set and carries
// acked (1 when the target pulled SDA low on the acknowledge clock). A new byte
// is taken once the sequencer is idle, even while the final word still
// waits in the output register. A START without a STOP before it starts
// from low lines, so no repeated start appears; the block does not repair
// this.
// ---------------------------------------------------------------------------
module i2c_master_byte_writer_unit (
  input  logic          clk,
  input  logic          rst,
  i2cmbw_in_if.sink     in_word,
  i2cmbw_out_if.source  out_word,
  i2cmbw_cfg_if.sink    cfg
);

  i2cmbw_pkg::cmd_t cmd;   // sequencer to datapath
  i2cmbw_pkg::sts_t sts;   // datapath to sequencer
  logic             in_ready;

  assign in_word.ready = in_ready;

  // phase sequencer
  i2cmbw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_word.valid),
    .in_start (in_word.send_start),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // line state, shifter, hold timer, output register, config register
  i2cmbw_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_word  (in_word),
    .out_word (out_word),
    .cfg      (cfg)
  );

endmodule
